// ----- sv/pedd_pkg.sv -----
// Shared types and defaults for the polygon edge dedup unit.
`timescale 1ns / 1ps

package pedd_pkg;

  localparam int VTX_W           = 16;
  localparam int SLOT_W          = 8;
  localparam int MAX_EDGES_DEF   = 256;
  localparam int VERTEX_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;

  typedef logic [VTX_W-1:0] vtx_t;

  typedef struct packed {
    logic vld;
    vtx_t lo;
    vtx_t hi;
  } edge_t;

  typedef struct packed {
    logic  clear;
    edge_t e0;
    edge_t e1;
  } cmd_t;

  typedef struct packed {
    vtx_t              lo;
    vtx_t              hi;
    logic [SLOT_W-1:0] slot;
    logic              ovf;
  } result_t;

endpackage

// ----- sv/pedd_front.sv -----
// Front end: accepts corner words and turns them into edge commands.
`timescale 1ns / 1ps

module pedd_front
  import pedd_pkg::*;
#(
  parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic vertex_valid,
  output logic vertex_stall,
  input  vtx_t vertex,
  input  logic last_of_polygon,
  input  logic new_mesh,
  output logic q_push,
  output cmd_t q_cmd,
  input  logic q_full
);

  localparam int   VW    = (VERTEX_BITS < VTX_W) ? VERTEX_BITS : VTX_W;
  localparam vtx_t VMASK = {VTX_W{1'b1}} >> (VTX_W - VW);

  logic in_polygon;
  vtx_t first_vertex;
  vtx_t prev_vertex;

  logic accept;
  logic open_poly;
  vtx_t v;
  vtx_t first_eff;

  function automatic edge_t make_edge(logic vld, vtx_t a, vtx_t b);
    edge_t e;
    e.vld = vld;
    e.lo  = (a < b) ? a : b;
    e.hi  = (a < b) ? b : a;
    return e;
  endfunction

  assign vertex_stall = q_full;
  assign accept       = vertex_valid && !q_full;

  always_comb begin
    v           = vertex & VMASK;
    open_poly   = new_mesh || !in_polygon;
    first_eff   = open_poly ? v : first_vertex;
    q_cmd.clear = new_mesh;
    q_cmd.e0    = make_edge(!open_poly, prev_vertex, v);
    q_cmd.e1    = make_edge(last_of_polygon, v, first_eff);
    q_push      = accept && (new_mesh || !open_poly || last_of_polygon);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_polygon   <= 1'b0;
      first_vertex <= '0;
      prev_vertex  <= '0;
    end else if (accept) begin
      prev_vertex <= v;
      if (open_poly) begin
        first_vertex <= v;
      end
      in_polygon <= !last_of_polygon;
    end
  end

endmodule

// ----- sv/pedd_queue.sv -----
// Short command queue between the front end and the table engine.
`timescale 1ns / 1ps

module pedd_queue
  import pedd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] fill;

  assign full    = (fill == CNTW'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNTW'(1);
      end else if (pop && !push) begin
        fill <= fill - CNTW'(1);
      end
    end
  end

endmodule

// ----- sv/pedd_back.sv -----
// Back end: scans the edge table, stores new edges and sends result words.
`timescale 1ns / 1ps

module pedd_back
  import pedd_pkg::*;
#(
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              edge_valid,
  input  logic              edge_stall,
  output vtx_t              low_vertex,
  output vtx_t              high_vertex,
  output logic [SLOT_W-1:0] edge_slot,
  output logic              overflow,
  output logic              last
);

  localparam int IW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int VW = (VERTEX_BITS < VTX_W) ? VERTEX_BITS : VTX_W;
  localparam int KW = 2 * VW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [KW-1:0] table_mem [MAX_EDGES];

  logic [1:0]    state;
  cmd_t          cmd;
  logic          cur;
  logic [CW-1:0] addr;
  logic [CW-1:0] count;
  logic          rd_vld;
  logic [KW-1:0] rd_data;
  result_t       res0;
  result_t       res1;
  logic          res0_v;
  logic          res1_v;
  result_t       out_r;
  logic          out_last;

  edge_t         cur_edge;
  logic [KW-1:0] key;
  logic          issue;
  logic          hit;
  logic          miss;
  logic          done;
  logic          room;
  logic          more;
  logic          out_free;
  logic          load0;
  logic          load1;
  result_t       nres;

  always_comb begin
    cur_edge  = cur ? cmd.e1 : cmd.e0;
    key       = {cur_edge.hi[VW-1:0], cur_edge.lo[VW-1:0]};
    issue     = (state == ST_SCAN) && (addr < count);
    hit       = (state == ST_SCAN) && rd_vld && (rd_data == key);
    miss      = (state == ST_SCAN) && !hit && !issue;
    done      = hit || miss;
    room      = (count != CW'(MAX_EDGES));
    more      = !cur && cmd.e1.vld;
    out_free  = !edge_valid || !edge_stall;
    load0     = (state == ST_OUT) && out_free && res0_v;
    load1     = (state == ST_OUT) && out_free && !res0_v && res1_v;
    nres.lo   = cur_edge.lo;
    nres.hi   = cur_edge.hi;
    nres.slot = room ? SLOT_W'(count) : '0;
    nres.ovf  = !room;
    q_pop     = (state == ST_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    rd_data <= table_mem[addr[IW-1:0]];
    if (miss && room) begin
      table_mem[count[IW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (miss && !cur) begin
      res0 <= nres;
    end
    if (miss && cur) begin
      res1 <= nres;
    end
    if (load0) begin
      out_r    <= res0;
      out_last <= !res1_v;
    end else if (load1) begin
      out_r    <= res1;
      out_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur        <= 1'b0;
      addr       <= '0;
      count      <= '0;
      rd_vld     <= 1'b0;
      res0_v     <= 1'b0;
      res1_v     <= 1'b0;
      edge_valid <= 1'b0;
    end else begin
      if (out_free) begin
        edge_valid <= load0 || load1;
      end
      case (state)
        ST_IDLE: begin
          rd_vld <= 1'b0;
          addr   <= '0;
          if (q_valid) begin
            if (q_cmd.clear) begin
              count <= '0;
            end
            if (q_cmd.e0.vld) begin
              cur   <= 1'b0;
              state <= ST_SCAN;
            end else if (q_cmd.e1.vld) begin
              cur   <= 1'b1;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (done) begin
            rd_vld <= 1'b0;
            addr   <= '0;
            if (miss) begin
              if (room) begin
                count <= count + CW'(1);
              end
              if (cur) begin
                res1_v <= 1'b1;
              end else begin
                res0_v <= 1'b1;
              end
            end
            if (more) begin
              cur <= 1'b1;
            end else begin
              state <= ST_OUT;
            end
          end else begin
            rd_vld <= issue;
            if (issue) begin
              addr <= addr + CW'(1);
            end
          end
        end
        ST_OUT: begin
          if (load0) begin
            res0_v <= 1'b0;
          end else if (load1) begin
            res1_v <= 1'b0;
          end else if (!res0_v && !res1_v) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign low_vertex  = out_r.lo;
  assign high_vertex = out_r.hi;
  assign edge_slot   = out_r.slot;
  assign overflow    = out_r.ovf;
  assign last        = out_last;

endmodule

// ----- sv/polygon_edge_dedup_unit.sv -----
// Top level of the polygon edge dedup unit: front end, command queue, table engine.
`timescale 1ns / 1ps

// Channel   Valid         Stall         Payload
// corner    vertex_valid  vertex_stall  vertex, last_of_polygon, new_mesh
// edge      edge_valid    edge_stall    low_vertex, high_vertex, edge_slot, overflow, last
//
// The front end takes one corner word per cycle while the command queue has room.
// Each edge is checked against the table through its single read port,
// one stored entry per cycle.
// Each command is fetched in the idle state and scanned, then its results are sent
// from the out state before the engine returns to idle.
// Reset is synchronous; the table needs no clearing pass since only filled slots are read.
// A stalled edge word holds the engine; corners keep flowing until the queue is full.

module polygon_edge_dedup_unit
  import pedd_pkg::*;
#(
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vertex_valid,
  output logic              vertex_stall,
  input  vtx_t              vertex,
  input  logic              last_of_polygon,
  input  logic              new_mesh,
  output logic              edge_valid,
  input  logic              edge_stall,
  output vtx_t              low_vertex,
  output vtx_t              high_vertex,
  output logic [SLOT_W-1:0] edge_slot,
  output logic              overflow,
  output logic              last
);

  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  pedd_front #(
    .VERTEX_BITS(VERTEX_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .vertex_valid   (vertex_valid),
    .vertex_stall   (vertex_stall),
    .vertex         (vertex),
    .last_of_polygon(last_of_polygon),
    .new_mesh       (new_mesh),
    .q_push         (q_push),
    .q_cmd          (q_push_cmd),
    .q_full         (q_full)
  );

  pedd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .full    (q_full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (q_pop)
  );

  pedd_back #(
    .MAX_EDGES  (MAX_EDGES),
    .VERTEX_BITS(VERTEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .edge_valid (edge_valid),
    .edge_stall (edge_stall),
    .low_vertex (low_vertex),
    .high_vertex(high_vertex),
    .edge_slot  (edge_slot),
    .overflow   (overflow),
    .last       (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("Command pushed into a full queue.");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("Command popped from an empty queue.");

  a_overflow_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (edge_valid && overflow) |-> (edge_slot == '0))
    else $error("Overflow edge word carries a nonzero slot.");

  a_edge_low_not_above_high: assert property (@(posedge clk) disable iff (rst)
    edge_valid |-> (low_vertex <= high_vertex))
    else $error("Edge word is not in ascending order.");

endmodule

// ----- sim/polygon_edge_dedup_unit_tb.sv -----
// Testbench for the polygon edge dedup unit: corner stimulus, edge prediction and checking.
`timescale 1ns / 1ps

module polygon_edge_dedup_unit_tb;
  import pedd_pkg::*;

  localparam int TABLE_SLOTS   = MAX_EDGES_DEF;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int DRAIN_CYCLES  = 600;

  typedef struct {
    vtx_t              lo;
    vtx_t              hi;
    logic [SLOT_W-1:0] slot;
    logic              ovf;
    logic              last;
  } edge_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              vertex_valid = 1'b0;
  logic              vertex_stall;
  vtx_t              vertex = '0;
  logic              last_of_polygon = 1'b0;
  logic              new_mesh = 1'b0;
  logic              edge_valid;
  logic              edge_stall = 1'b0;
  vtx_t              low_vertex;
  vtx_t              high_vertex;
  logic [SLOT_W-1:0] edge_slot;
  logic              overflow;
  logic              last;

  edge_word_t  expected_edges[$];
  logic [31:0] known_edges[TABLE_SLOTS];
  int          known_count = 0;
  vtx_t        poly_first = '0;
  vtx_t        poly_prev = '0;
  logic        poly_open = 1'b0;

  int   src_idle_pct = 9;
  int   snk_stall_pct = 56;
  int   error_count = 0;
  int   idle_cycles = 0;
  logic stimulus_done = 1'b0;

  polygon_edge_dedup_unit dut (
    .clk            (clk),
    .rst            (rst),
    .vertex_valid   (vertex_valid),
    .vertex_stall   (vertex_stall),
    .vertex         (vertex),
    .last_of_polygon(last_of_polygon),
    .new_mesh       (new_mesh),
    .edge_valid     (edge_valid),
    .edge_stall     (edge_stall),
    .low_vertex     (low_vertex),
    .high_vertex    (high_vertex),
    .edge_slot      (edge_slot),
    .overflow       (overflow),
    .last           (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int lookup_edge(vtx_t a, vtx_t b);
    vtx_t        lo;
    vtx_t        hi;
    logic [31:0] key;
    edge_word_t  w;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    key = {hi, lo};
    for (int k = 0; k < known_count; k++) begin
      if (known_edges[k] == key) return 0;
    end
    w.lo   = lo;
    w.hi   = hi;
    w.last = 1'b0;
    if (known_count < TABLE_SLOTS) begin
      w.slot = known_count[SLOT_W-1:0];
      w.ovf  = 1'b0;
      known_edges[known_count] = key;
      known_count++;
    end else begin
      w.slot = '0;
      w.ovf  = 1'b1;
    end
    expected_edges.push_back(w);
    return 1;
  endfunction

  function automatic void predict_corner_edges(vtx_t v, logic closes, logic fresh);
    int n;
    n = 0;
    if (fresh) begin
      known_count = 0;
      poly_open   = 1'b0;
    end
    if (!poly_open) begin
      poly_first = v;
      poly_prev  = v;
      poly_open  = 1'b1;
    end else begin
      n += lookup_edge(poly_prev, v);
      poly_prev = v;
    end
    if (closes) begin
      n += lookup_edge(v, poly_first);
      poly_open = 1'b0;
    end
    if (n > 0) expected_edges[expected_edges.size()-1].last = 1'b1;
  endfunction

  task automatic send_corner(vtx_t v, logic closes, logic fresh);
    while ($urandom_range(99) < src_idle_pct) begin
      vertex_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_valid    <= 1'b1;
    vertex          <= v;
    last_of_polygon <= closes;
    new_mesh        <= fresh;
    @(posedge clk);
    while (vertex_stall) @(posedge clk);
    predict_corner_edges(v, closes, fresh);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    edge_word_t w;
    if (rst) begin
      edge_stall <= 1'b0;
    end else begin
      edge_stall <= ($urandom_range(99) < snk_stall_pct);
      if (edge_valid && !edge_stall) begin
        if (expected_edges.size() == 0) begin
          $error("unexpected edge word %0h-%0h", low_vertex, high_vertex);
          error_count++;
        end else begin
          w = expected_edges.pop_front();
          check_field("low_vertex", 32'(w.lo), 32'(low_vertex));
          check_field("high_vertex", 32'(w.hi), 32'(high_vertex));
          check_field("edge_slot", 32'(w.slot), 32'(edge_slot));
          check_field("overflow", 32'(w.ovf), 32'(overflow));
          check_field("last", 32'(w.last), 32'(last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || stimulus_done || (vertex_valid && !vertex_stall) || (edge_valid && !edge_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_corner_cases();
    send_corner(16'h0000, 1'b1, 1'b1);
    send_corner(16'hFFFF, 1'b1, 1'b0);
    send_corner(16'h0000, 1'b0, 1'b0);
    send_corner(16'hFFFF, 1'b0, 1'b0);
    send_corner(16'h8000, 1'b1, 1'b0);
    send_corner(16'h0005, 1'b0, 1'b0);
    send_corner(16'h000A, 1'b1, 1'b0);
    send_corner(16'h8000, 1'b0, 1'b0);
    send_corner(16'hFFFF, 1'b0, 1'b0);
    send_corner(16'h0000, 1'b1, 1'b0);
    send_corner(16'h1234, 1'b0, 1'b0);
    send_corner(16'h4321, 1'b0, 1'b1);
    send_corner(16'h1234, 1'b1, 1'b0);
    send_corner(16'h5555, 1'b0, 1'b0);
    send_corner(16'hAAAA, 1'b0, 1'b0);
    send_corner(16'h5555, 1'b0, 1'b0);
    send_corner(16'hAAAA, 1'b1, 1'b0);
    send_corner(16'h00FF, 1'b1, 1'b1);
    send_corner(16'h00FF, 1'b1, 1'b0);
  endtask

  task automatic test_table_overflow();
    vtx_t corners[300];
    for (int i = 0; i < 300; i++) begin
      corners[i] = {i[8:0], 7'($urandom)};
      send_corner(corners[i], 1'b0, i == 0);
    end
    for (int i = 0; i < 10; i++) send_corner(corners[i], 1'b0, 1'b0);
    send_corner(16'($urandom), 1'b1, 1'b0);
    send_corner(corners[0], 1'b0, 1'b0);
    send_corner(corners[1], 1'b1, 1'b0);
  endtask

  task automatic test_random_meshes(int n_items);
    vtx_t pool[8];
    int   pool_size;
    int   sent;
    int   len;
    logic fresh;
    logic closes;
    vtx_t v;
    sent      = 0;
    pool_size = 1;
    while (sent < n_items) begin
      fresh = (sent == 0) || ($urandom_range(99) < 12);
      if (fresh) begin
        pool_size = $urandom_range(3, 8);
        for (int i = 0; i < 8; i++) pool[i] = 16'($urandom);
      end
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 94) v = pool[$urandom_range(pool_size - 1)];
        else v = 16'($urandom);
        closes = (k == len - 1) && ($urandom_range(99) < 95);
        if ($urandom_range(99) < 2) closes = 1'b1;
        send_corner(v, closes, (fresh && k == 0) || ($urandom_range(99) < 2));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 9;
    snk_stall_pct = 56;
    test_corner_cases();
    test_random_meshes(550);

    src_idle_pct  = 56;
    snk_stall_pct = 9;
    test_table_overflow();
    test_random_meshes(550);

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    test_random_meshes(560);

    vertex_valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    stimulus_done <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_edges.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
